// ===== src/tkm_pkg.sv =====
// ----------------------------------------------------------------------------
// tkm_pkg
// Shared constants and types for the touch key to note message encoder.
// ----------------------------------------------------------------------------
package tkm_pkg;

    localparam int KEY_COUNT  = 15;
    localparam int NOTE_KEYS  = 12;
    localparam int KEY_W      = 4;
    localparam int SHIFT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [KEY_W-1:0] KEY_OCT_UP   = 4'd12;
    localparam logic [KEY_W-1:0] KEY_OCT_DOWN = 4'd13;
    localparam logic [KEY_W-1:0] KEY_LAST_NOTE = 4'd11;

    localparam logic signed [SHIFT_W-1:0] SEMIS_PER_OCTAVE = 7'sd12;
    localparam logic [2:0] MAX_LIMIT = 3'd5;

    localparam logic [7:0] STATUS_ON  = 8'h90;
    localparam logic [7:0] STATUS_OFF = 8'h80;

    localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_NOTE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_VELOCITY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_LIMIT  = 2'd3;

    localparam logic [3:0] RST_MIDI_CHANNEL  = 4'd0;
    localparam logic [6:0] RST_BASE_NOTE     = 7'd60;
    localparam logic [6:0] RST_NOTE_VELOCITY = 7'd100;
    localparam logic [2:0] RST_OCTAVE_LIMIT  = 3'd3;

    typedef struct packed {
        logic                      is_on;
        logic [KEY_W-1:0]          key;
        logic signed [SHIFT_W-1:0] shift;
        logic                      last;
    } t_msg;

endpackage

// ===== src/tkm_seq.sv =====
// ----------------------------------------------------------------------------
// tkm_seq
// Key sequencer: shifts press and release masks out one key per cycle while
// messages flow, steps the octave shift, issues one message per note event.
// ----------------------------------------------------------------------------
module tkm_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tkm_pkg::KEY_COUNT-1:0] i_touch_keys,
    input  logic [2:0]                    i_octave_limit,
    output logic                          o_msg_valid,
    input  logic                          i_msg_ready,
    output tkm_pkg::t_msg                 o_msg
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ON   = 2'd1;
    localparam logic [1:0] S_OCT  = 2'd2;
    localparam logic [1:0] S_OFF  = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [tkm_pkg::KEY_COUNT-1:0]       r_active, n_active;
    logic signed [tkm_pkg::SHIFT_W-1:0]  r_shift, n_shift;
    logic [tkm_pkg::NOTE_KEYS-1:0]       r_on, n_on;
    logic [tkm_pkg::NOTE_KEYS-1:0]       r_off, n_off;
    logic [1:0]                          r_oct, n_oct;
    logic [tkm_pkg::KEY_W-1:0]           r_key, n_key;

    logic [tkm_pkg::KEY_COUNT-1:0] pressed;
    logic [tkm_pkg::KEY_COUNT-1:0] released;
    logic [2:0]                    lim;
    logic [6:0]                    span;
    logic signed [7:0]             shift_x;
    logic signed [7:0]             span_pos;
    logic signed [7:0]             span_neg;

    assign pressed  = i_touch_keys & ~r_active;
    assign released = (pressed != '0) ? r_active : (r_active & ~i_touch_keys);

    // limit times twelve as two shifted copies
    assign lim      = (i_octave_limit > tkm_pkg::MAX_LIMIT) ? tkm_pkg::MAX_LIMIT
                                                             : i_octave_limit;
    assign span     = {1'b0, lim, 3'b000} + {2'b00, lim, 2'b00};
    assign shift_x  = {r_shift[tkm_pkg::SHIFT_W-1], r_shift};
    assign span_pos = $signed({1'b0, span});
    assign span_neg = -span_pos;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_shift     = r_shift;
        n_on        = r_on;
        n_off       = r_off;
        n_oct       = r_oct;
        n_key       = r_key;
        o_msg_valid = 1'b0;
        o_msg.is_on = (r_state == S_ON);
        o_msg.key   = r_key;
        o_msg.shift = r_shift;
        o_msg.last  = (r_state == S_ON)
                    ? ((r_on[tkm_pkg::NOTE_KEYS-1:1] == '0) && (r_off == '0))
                    : (r_off[tkm_pkg::NOTE_KEYS-1:1] == '0);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_active = i_touch_keys;
                    n_on     = pressed[tkm_pkg::NOTE_KEYS-1:0];
                    n_off    = released[tkm_pkg::NOTE_KEYS-1:0];
                    n_oct    = pressed[tkm_pkg::KEY_OCT_DOWN:tkm_pkg::KEY_OCT_UP];
                    n_key    = '0;
                    n_state  = S_ON;
                end
            end
            S_ON: begin
                if (r_on == '0) begin
                    n_key   = tkm_pkg::KEY_OCT_UP;
                    n_state = S_OCT;
                end else begin
                    o_msg_valid = r_on[0];
                    if (!r_on[0] || i_msg_ready) begin
                        n_on  = {1'b0, r_on[tkm_pkg::NOTE_KEYS-1:1]};
                        n_key = r_key + 1'b1;
                    end
                end
            end
            S_OCT: begin
                if (r_oct == '0) begin
                    n_key   = '0;
                    n_state = S_OFF;
                end else begin
                    if (r_oct[0]) begin
                        if (r_key == tkm_pkg::KEY_OCT_UP) begin
                            if (shift_x < span_pos) begin
                                n_shift = r_shift + tkm_pkg::SEMIS_PER_OCTAVE;
                            end
                        end else if (shift_x > span_neg) begin
                            n_shift = r_shift - tkm_pkg::SEMIS_PER_OCTAVE;
                        end
                    end
                    n_oct = {1'b0, r_oct[1]};
                    n_key = r_key + 1'b1;
                end
            end
            S_OFF: begin
                if (r_off == '0) begin
                    n_state = S_IDLE;
                end else begin
                    o_msg_valid = r_off[0];
                    if (!r_off[0] || i_msg_ready) begin
                        n_off = {1'b0, r_off[tkm_pkg::NOTE_KEYS-1:1]};
                        n_key = r_key + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_shift  <= '0;
            r_on     <= '0;
            r_off    <= '0;
            r_oct    <= '0;
            r_key    <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_shift  <= n_shift;
            r_on     <= n_on;
            r_off    <= n_off;
            r_oct    <= n_oct;
            r_key    <= n_key;
        end
    end

endmodule

// ===== src/tkm_out.sv =====
// ----------------------------------------------------------------------------
// tkm_out
// Message builder: forms status, clamped note and velocity for one request
// and holds them in the output register until the transaction completes.
// ----------------------------------------------------------------------------
module tkm_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_msg_valid,
    output logic          o_msg_ready,
    input  tkm_pkg::t_msg i_msg,
    input  logic [3:0]    i_midi_channel,
    input  logic [6:0]    i_base_note,
    input  logic [6:0]    i_note_velocity,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_status_byte,
    output logic [6:0]    o_note_number,
    output logic [6:0]    o_velocity_byte,
    output logic          o_last_message
);

    logic       r_valid, n_valid;
    logic [7:0] r_status;
    logic [6:0] r_note;
    logic [6:0] r_vel;
    logic       r_last;

    logic signed [9:0] sum;
    logic [6:0]        note;
    logic              load;

    assign sum = $signed({3'b000, i_base_note})
               + $signed({6'b000000, i_msg.key})
               + $signed({{3{i_msg.shift[tkm_pkg::SHIFT_W-1]}}, i_msg.shift});

    always_comb begin
        priority if (sum < 10'sd0) begin
            note = 7'd0;
        end else if (sum > 10'sd127) begin
            note = 7'd127;
        end else begin
            note = sum[6:0];
        end
    end

    assign o_msg_ready = !r_valid || i_out_ready;
    assign load        = i_msg_valid && o_msg_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= (i_msg.is_on ? tkm_pkg::STATUS_ON : tkm_pkg::STATUS_OFF)
                      | {4'b0000, i_midi_channel};
            r_note   <= note;
            r_vel    <= i_msg.is_on ? i_note_velocity : 7'd0;
            r_last   <= i_msg.last;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_status_byte   = r_status;
    assign o_note_number   = r_note;
    assign o_velocity_byte = r_vel;
    assign o_last_message  = r_last;

endmodule

// ===== src/touch_keys_to_midi_notes.sv =====
// ----------------------------------------------------------------------------
// touch_keys_to_midi_notes
// Turns touch key snapshots into note-on and note-off messages.
// ----------------------------------------------------------------------------
// One snapshot is taken per input transaction and then scanned one key per
// cycle by the key sequencer while the output side does not stall: the newly
// touched note keys first, then the octave up and down keys, then the
// released note keys. A scan phase ends as soon as its remaining mask is
// empty; the input is ready again once the scan is done. Each message is
// produced from a single output register and carries last_message on the
// final one of its snapshot. Configuration writes are accepted at any time
// and are meant to be issued while no snapshot is being scanned.
// ----------------------------------------------------------------------------
module touch_keys_to_midi_notes (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tkm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tkm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tkm_pkg::KEY_COUNT-1:0]  i_touch_keys,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_status_byte,
    output logic [6:0]                     o_note_number,
    output logic [6:0]                     o_velocity_byte,
    output logic                           o_last_message
);

    logic [3:0] r_midi_channel;
    logic [6:0] r_base_note;
    logic [6:0] r_note_velocity;
    logic [2:0] r_octave_limit;

    logic          msg_valid;
    logic          msg_ready;
    tkm_pkg::t_msg msg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midi_channel  <= tkm_pkg::RST_MIDI_CHANNEL;
            r_base_note     <= tkm_pkg::RST_BASE_NOTE;
            r_note_velocity <= tkm_pkg::RST_NOTE_VELOCITY;
            r_octave_limit  <= tkm_pkg::RST_OCTAVE_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tkm_pkg::REG_MIDI_CHANNEL:  r_midi_channel  <= i_cfg_data[3:0];
                tkm_pkg::REG_BASE_NOTE:     r_base_note     <= i_cfg_data[6:0];
                tkm_pkg::REG_NOTE_VELOCITY: r_note_velocity <= i_cfg_data[6:0];
                tkm_pkg::REG_OCTAVE_LIMIT:  r_octave_limit  <= i_cfg_data[2:0];
                default: begin
                    r_midi_channel <= r_midi_channel;
                end
            endcase
        end
    end

    tkm_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_touch_keys   (i_touch_keys),
        .i_octave_limit (r_octave_limit),
        .o_msg_valid    (msg_valid),
        .i_msg_ready    (msg_ready),
        .o_msg          (msg)
    );

    tkm_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_msg_valid     (msg_valid),
        .o_msg_ready     (msg_ready),
        .i_msg           (msg),
        .i_midi_channel  (r_midi_channel),
        .i_base_note     (r_base_note),
        .i_note_velocity (r_note_velocity),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status_byte   (o_status_byte),
        .o_note_number   (o_note_number),
        .o_velocity_byte (o_velocity_byte),
        .o_last_message  (o_last_message)
    );

endmodule

// ===== bench/tb_touch_keys_to_midi_notes.sv =====
// ----------------------------------------------------------------------------
// tb_touch_keys_to_midi_notes
// Self-checking bench for the touch key to note message encoder.
// ----------------------------------------------------------------------------
// Touch snapshots go in through a valid/ready channel. A scoreboard keeps its
// own key mask, octave shift and register copies, and predicts the note-on
// and note-off messages for each snapshot. Every message the block sends is
// compared field by field with the oldest prediction. A short directed list
// comes first: all keys at once, the octave keys pushed past the limit, the
// idle key and a press while a note key stays held. Random phases follow.
// Each phase runs under its own register setting, including all-ones and
// all-zeros data. Both handshake sides pause at random, with runs of
// back-to-back transactions mixed in.
// ----------------------------------------------------------------------------
module tb_touch_keys_to_midi_notes;
    import tkm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 62;

    typedef struct {
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] vel;
        logic       last;
    } note_msg_t;

    class note_scoreboard;
        logic [3:0]           channel;
        logic [6:0]           base;
        logic [6:0]           velocity;
        logic [2:0]           limit;
        logic [KEY_COUNT-1:0] held_keys;
        int                   shift;
        int                   errors;
        note_msg_t            expected_msgs[$];

        function new();
            channel   = RST_MIDI_CHANNEL;
            base      = RST_BASE_NOTE;
            velocity  = RST_NOTE_VELOCITY;
            limit     = RST_OCTAVE_LIMIT;
            held_keys = '0;
            shift     = 0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_msgs.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MIDI_CHANNEL:  channel = data[3:0];
                REG_BASE_NOTE:     base = data;
                REG_NOTE_VELOCITY: velocity = data;
                REG_OCTAVE_LIMIT:  limit = data[2:0];
                default: ;
            endcase
        endfunction

        function void push_msg(bit on, int key);
            note_msg_t m;
            int        n;
            n = int'(base) + key + shift;
            if (n < 0) n = 0;
            if (n > 127) n = 127;
            m.status = (on ? STATUS_ON : STATUS_OFF) | {4'h0, channel};
            m.note   = n[6:0];
            m.vel    = on ? velocity : 7'd0;
            m.last   = 1'b0;
            expected_msgs.push_back(m);
        endfunction

        function void note_snapshot(logic [KEY_COUNT-1:0] keys);
            logic [KEY_COUNT-1:0] pressed;
            logic [KEY_COUNT-1:0] released;
            note_msg_t            m;
            int                   span;
            int                   first;
            pressed  = keys & ~held_keys;
            released = held_keys & ~keys;
            // any new press ends every held note
            if (pressed != '0) released = held_keys & ~pressed;
            held_keys = keys;
            span  = (limit > MAX_LIMIT ? int'(MAX_LIMIT) : int'(limit)) * int'(SEMIS_PER_OCTAVE);
            first = expected_msgs.size();
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (pressed[k]) begin
                    if (k == int'(KEY_OCT_UP)) begin
                        if (shift < span) shift += int'(SEMIS_PER_OCTAVE);
                    end else if (k == int'(KEY_OCT_DOWN)) begin
                        if (shift > -span) shift -= int'(SEMIS_PER_OCTAVE);
                    end else if (k <= int'(KEY_LAST_NOTE)) begin
                        push_msg(1'b1, k);
                    end
                end
            end
            for (int k = 0; k < NOTE_KEYS; k++) begin
                if (released[k]) push_msg(1'b0, k);
            end
            if (expected_msgs.size() > first) begin
                m = expected_msgs.pop_back();
                m.last = 1'b1;
                expected_msgs.push_back(m);
            end
        endfunction

        function void check_message(logic [7:0] status, logic [6:0] note, logic [6:0] vel,
                                    logic last);
            note_msg_t m;
            if (expected_msgs.size() == 0) begin
                $error("unexpected message: status %0h note %0d", status, note);
                errors++;
                return;
            end
            m = expected_msgs.pop_front();
            if (status !== m.status) begin
                $error("status_byte: expected %0h, actual %0h", m.status, status);
                errors++;
            end
            if (note !== m.note) begin
                $error("note_number: expected %0d, actual %0d", m.note, note);
                errors++;
            end
            if (vel !== m.vel) begin
                $error("velocity_byte: expected %0d, actual %0d", m.vel, vel);
                errors++;
            end
            if (last !== m.last) begin
                $error("last_message: expected %0b, actual %0b", m.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [KEY_COUNT-1:0]  i_touch_keys;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [7:0]            o_status_byte;
    logic [6:0]            o_note_number;
    logic [6:0]            o_velocity_byte;
    logic                  o_last_message;

    note_scoreboard       notes = new();
    int                   in_calm = 0;
    int                   out_calm = 0;
    int                   idle_cycles = 0;
    logic [KEY_COUNT-1:0] last_keys = '0;
    logic [KEY_COUNT-1:0] directed_keys[$] = '{
        15'h0000, 15'h0001, 15'h0FFF, 15'h0000, 15'h7FFF, 15'h0000,
        15'h1000, 15'h0000, 15'h1000, 15'h0000, 15'h1000, 15'h0000,
        15'h1000, 15'h1001, 15'h0000, 15'h4000, 15'h0000, 15'h2000,
        15'h0000, 15'h0800, 15'h0801, 15'h0801
    };

    touch_keys_to_midi_notes u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_touch_keys    (i_touch_keys),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status_byte   (o_status_byte),
        .o_note_number   (o_note_number),
        .o_velocity_byte (o_velocity_byte),
        .o_last_message  (o_last_message)
    );

    always #2 i_clk = ~i_clk;

    // runs of zero wait between spells of random waits
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic logic [KEY_COUNT-1:0] next_snapshot(input logic [KEY_COUNT-1:0] held);
        logic [KEY_COUNT-1:0] keys;
        int                   pick;
        int                   idx;
        keys = held;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            keys = KEY_COUNT'($urandom_range(0, (1 << KEY_COUNT) - 1));
        end else if (pick < 10) begin
            keys = '0;
        end else if (pick < 13) begin
            keys = held;
        end else if (pick < 33) begin
            idx = $urandom_range(int'(KEY_OCT_UP), int'(KEY_OCT_DOWN));
            keys[idx] = ~keys[idx];
        end else begin
            repeat ($urandom_range(1, 3)) begin
                idx = $urandom_range(0, KEY_COUNT - 1);
                keys[idx] = ~keys[idx];
            end
        end
        return keys;
    endfunction

    task automatic send_snapshot(input logic [KEY_COUNT-1:0] keys);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_touch_keys <= keys;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        notes.note_snapshot(keys);
        last_keys = keys;
    endtask

    task automatic run_random(input int count);
        logic [KEY_COUNT-1:0] keys;
        int                   changed;
        changed = 0;
        while (changed < count) begin
            keys = next_snapshot(last_keys);
            if (keys != last_keys) changed++;
            send_snapshot(keys);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        notes.write_reg(idx, data);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] ch, input logic [CFG_DATA_W-1:0] base,
                              input logic [CFG_DATA_W-1:0] vel, input logic [CFG_DATA_W-1:0] lim);
        write_reg(REG_MIDI_CHANNEL, ch);
        write_reg(REG_BASE_NOTE, base);
        write_reg(REG_NOTE_VELOCITY, vel);
        write_reg(REG_OCTAVE_LIMIT, lim);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (notes.pending() != 0) @(posedge i_clk);
        // snapshots with no message may still be scanning
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int gap;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap(out_calm);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            notes.check_message(o_status_byte, o_note_number, o_velocity_byte, o_last_message);
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_touch_keys <= '0;
        i_out_ready  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_keys[i]) send_snapshot(directed_keys[i]);
        settle();

        // all-ones data: top channel, clamp high, limit above five
        write_regs(7'h7F, 7'h7F, 7'h7F, 7'h7F);
        run_random(PHASE_ITEMS);
        settle();

        write_regs(7'h00, 7'h00, 7'h00, 7'h00);
        run_random(PHASE_ITEMS);
        settle();

        repeat (2) begin
            write_regs(CFG_DATA_W'($urandom_range(0, 127)), CFG_DATA_W'($urandom_range(0, 127)),
                       CFG_DATA_W'($urandom_range(0, 127)), CFG_DATA_W'($urandom_range(0, 127)));
            run_random(PHASE_ITEMS);
            settle();
        end

        // low base with full limit, notes clamp at zero
        write_regs(7'd5, 7'd0, 7'd1, 7'd5);
        run_random(PHASE_ITEMS);
        settle();

        if (notes.pending() != 0) $error("%0d messages never arrived", notes.pending());
        if (notes.errors == 0 && notes.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
